// ===== hw/rtl/ucodec_pkg.sv =====
// Shared types, constants and helper functions for the URL percent codec.
// No dependencies; imported by every module of the codec.
`default_nettype none

package ucodec_pkg;

  // Configuration register indexes.
  localparam int unsigned REG_IDX_W = 3;
  localparam logic [REG_IDX_W-1:0] REG_MODE    = 3'd0;
  localparam logic [REG_IDX_W-1:0] REG_UNSAFE0 = 3'd1;
  localparam logic [REG_IDX_W-1:0] REG_UNSAFE1 = 3'd2;
  localparam logic [REG_IDX_W-1:0] REG_UNSAFE2 = 3'd3;
  localparam logic [REG_IDX_W-1:0] REG_UNSAFE3 = 3'd4;

  localparam int unsigned CFG_DATA_W = 64;

  // Reset contents of the unsafe set, one 64-bit slice per register.
  localparam logic [63:0] UNSAFE0_RST = 64'hFC00_98FF_FFFF_FFFE;
  localparam logic [63:0] UNSAFE1_RST = 64'hF000_0001_7800_0001;
  localparam logic [63:0] UNSAFE2_RST = 64'hFFFF_FFFF_FFFF_FFFF;
  localparam logic [63:0] UNSAFE3_RST = 64'hFFFF_FFFF_FFFF_FFFF;

  localparam logic [7:0] CH_PCT = 8'h25;

  // Depth of the group queue between front and back; power of two.
  localparam int unsigned QDEPTH = 2;
  localparam int unsigned QAW    = (QDEPTH > 1) ? $clog2(QDEPTH) : 1;

  typedef enum logic {
    MODE_ENCODE = 1'b0,
    MODE_DECODE = 1'b1
  } mode_t;

  // Decoder hold state: nothing, a '%', or a '%' plus one hex digit.
  typedef enum logic [1:0] {
    HELD_NONE  = 2'd0,
    HELD_PCT   = 2'd1,
    HELD_DIGIT = 2'd2
  } held_t;

  typedef struct packed {
    logic                  en;
    logic [REG_IDX_W-1:0]  index;
    logic [CFG_DATA_W-1:0] data;
  } cfg_wr_t;

  // Up to three output bytes produced by one input byte.
  typedef struct packed {
    logic [2:0][7:0] bytes;
    logic [1:0]      count;
    logic            last;
  } group_t;

  function automatic logic [7:0] hex_char(input logic [3:0] nib);
    hex_char = (nib < 4'd10) ? (8'h30 + {4'd0, nib}) : (8'h37 + {4'd0, nib});
  endfunction

  // Bit 4 set: not an uppercase hex digit. Otherwise bits 3:0 hold its value.
  function automatic logic [4:0] hex_val(input logic [7:0] c);
    logic [7:0] d;
    d = 8'd0;
    if (c >= 8'h30 && c <= 8'h39) begin
      d = c - 8'h30;
      hex_val = {1'b0, d[3:0]};
    end else if (c >= 8'h41 && c <= 8'h46) begin
      d = c - 8'h37;
      hex_val = {1'b0, d[3:0]};
    end else begin
      hex_val = 5'h10;
    end
  endfunction

endpackage

`default_nettype wire

// ===== hw/rtl/ucodec_front.sv =====
// Front end of the URL percent codec: config registers, byte classification,
// decoder hold state and group build. Depends on ucodec_pkg.
`default_nettype none

module ucodec_front (
  input  wire logic              clk,
  input  wire logic              rst,
  input  wire ucodec_pkg::cfg_wr_t cfg,
  input  wire logic              push,
  input  wire logic [7:0]        in_byte,
  input  wire logic              in_last,
  input  wire logic              q_full,
  output      logic              q_push,
  output      ucodec_pkg::group_t q_data
);
  import ucodec_pkg::*;

  mode_t       mode;
  logic [63:0] unsafe0, unsafe1, unsafe2, unsafe3;
  held_t       held, held_next;
  logic [3:0]  nibble, nibble_next;

  logic        accept;
  logic [4:0]  hv;
  logic        is_hex;
  logic        fresh_emit;
  logic [7:0]  lookup_idx;
  logic        is_unsafe;
  logic [255:0] unsafe_set;
  group_t      grp;

  assign accept     = push && !q_full;
  assign unsafe_set = {unsafe3, unsafe2, unsafe1, unsafe0};

  always_comb begin
    held_next   = held;
    nibble_next = nibble;
    grp         = '0;
    hv          = hex_val(in_byte);
    is_hex      = !hv[4];
    // a fresh '%' is held unless it closes the string
    fresh_emit  = !(in_byte == CH_PCT && !in_last);
    lookup_idx  = (mode == MODE_DECODE) ? {nibble, hv[3:0]} : in_byte;
    is_unsafe   = unsafe_set[lookup_idx];

    if (mode == MODE_ENCODE) begin
      if (is_unsafe) begin
        grp.bytes[0] = CH_PCT;
        grp.bytes[1] = hex_char(in_byte[7:4]);
        grp.bytes[2] = hex_char(in_byte[3:0]);
        grp.count    = 2'd3;
      end else begin
        grp.bytes[0] = in_byte;
        grp.count    = 2'd1;
      end
    end else begin
      unique case (held)
        HELD_NONE: begin
          if (fresh_emit) begin
            grp.bytes[0] = in_byte;
            grp.count    = 2'd1;
          end else begin
            held_next = HELD_PCT;
          end
        end
        HELD_PCT: begin
          if (is_hex) begin
            held_next   = HELD_DIGIT;
            nibble_next = hv[3:0];
            if (in_last) begin
              grp.bytes[0] = CH_PCT;
              grp.bytes[1] = in_byte;
              grp.count    = 2'd2;
              held_next    = HELD_NONE;
              nibble_next  = 4'd0;
            end
          end else begin
            grp.bytes[0] = CH_PCT;
            nibble_next  = 4'd0;
            if (fresh_emit) begin
              grp.bytes[1] = in_byte;
              grp.count    = 2'd2;
              held_next    = HELD_NONE;
            end else begin
              grp.count = 2'd1;
              held_next = HELD_PCT;
            end
          end
        end
        HELD_DIGIT: begin
          nibble_next = 4'd0;
          if (is_hex) begin
            held_next = HELD_NONE;
            if (is_unsafe) begin
              grp.bytes[0] = lookup_idx;
              grp.count    = 2'd1;
            end else begin
              grp.bytes[0] = CH_PCT;
              grp.bytes[1] = hex_char(nibble);
              grp.bytes[2] = in_byte;
              grp.count    = 2'd3;
            end
          end else begin
            grp.bytes[0] = CH_PCT;
            grp.bytes[1] = hex_char(nibble);
            if (fresh_emit) begin
              grp.bytes[2] = in_byte;
              grp.count    = 2'd3;
              held_next    = HELD_NONE;
            end else begin
              grp.count = 2'd2;
              held_next = HELD_PCT;
            end
          end
        end
        default: begin
          held_next   = HELD_NONE;
          nibble_next = 4'd0;
        end
      endcase
    end
    grp.last = in_last;
  end

  assign q_push = accept && (grp.count != 2'd0);
  assign q_data = grp;

  always_ff @(posedge clk) begin
    if (rst) begin
      mode    <= MODE_ENCODE;
      unsafe0 <= UNSAFE0_RST;
      unsafe1 <= UNSAFE1_RST;
      unsafe2 <= UNSAFE2_RST;
      unsafe3 <= UNSAFE3_RST;
      held    <= HELD_NONE;
      nibble  <= 4'd0;
    end else if (cfg.en) begin
      unique case (cfg.index)
        REG_MODE: begin
          mode   <= mode_t'(cfg.data[0]);
          held   <= HELD_NONE;
          nibble <= 4'd0;
        end
        REG_UNSAFE0: unsafe0 <= cfg.data;
        REG_UNSAFE1: unsafe1 <= cfg.data;
        REG_UNSAFE2: unsafe2 <= cfg.data;
        REG_UNSAFE3: unsafe3 <= cfg.data;
        default: ;
      endcase
    end else if (accept) begin
      held   <= held_next;
      nibble <= nibble_next;
    end
  end

  a_encode_holds_nothing: assert property (@(posedge clk) disable iff (rst)
    mode == MODE_ENCODE |-> held == HELD_NONE)
    else $error("decoder hold state set in encode mode");

  a_last_flushes: assert property (@(posedge clk) disable iff (rst)
    accept && in_last && !cfg.en |=> held == HELD_NONE && nibble == 4'd0)
    else $error("held bytes survive the end of a string");

endmodule

`default_nettype wire

// ===== hw/rtl/ucodec_fifo.sv =====
// Short queue of byte groups between the codec front and back ends.
// Depends on ucodec_pkg (group_t, QDEPTH, QAW).
`default_nettype none

module ucodec_fifo (
  input  wire logic               clk,
  input  wire logic               rst,
  input  wire logic               wr,
  input  wire ucodec_pkg::group_t wr_data,
  output      logic               full,
  input  wire logic               rd,
  output      ucodec_pkg::group_t rd_data,
  output      logic               empty
);
  import ucodec_pkg::*;

  group_t         mem [QDEPTH];
  logic [QAW-1:0] wptr, rptr;
  logic [QAW:0]   cnt;
  logic           do_wr, do_rd;

  assign full    = cnt == (QAW+1)'(QDEPTH);
  assign empty   = cnt == '0;
  assign do_wr   = wr && !full;
  assign do_rd   = rd && !empty;
  assign rd_data = mem[rptr];

  always_ff @(posedge clk) begin
    if (do_wr) begin
      mem[wptr] <= wr_data;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      wptr <= '0;
      rptr <= '0;
      cnt  <= '0;
    end else begin
      if (do_wr) wptr <= wptr + 1'b1;
      if (do_rd) rptr <= rptr + 1'b1;
      if (do_wr && !do_rd) cnt <= cnt + 1'b1;
      else if (do_rd && !do_wr) cnt <= cnt - 1'b1;
    end
  end

  a_no_overfill: assert property (@(posedge clk) disable iff (rst)
    cnt <= (QAW+1)'(QDEPTH) && !(wr && full))
    else $error("group queue overflow");

endmodule

`default_nettype wire

// ===== hw/rtl/ucodec_back.sv =====
// Back end of the URL percent codec: walks the head group one byte a beat.
// Depends on ucodec_pkg (group_t).
`default_nettype none

module ucodec_back (
  input  wire logic               clk,
  input  wire logic               rst,
  input  wire ucodec_pkg::group_t head,
  input  wire logic               q_empty,
  output      logic               q_pop,
  input  wire logic               pop,
  output      logic               empty,
  output      logic [7:0]         out_byte,
  output      logic               out_last
);
  import ucodec_pkg::*;

  logic [1:0] idx;
  logic       last_beat;
  logic       take;

  assign empty     = q_empty;
  assign take      = pop && !q_empty;
  assign last_beat = idx == (head.count - 2'd1);
  assign q_pop     = take && last_beat;
  assign out_last  = head.last && last_beat;

  always_comb begin
    case (idx)
      2'd0:    out_byte = head.bytes[0];
      2'd1:    out_byte = head.bytes[1];
      default: out_byte = head.bytes[2];
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      idx <= 2'd0;
    end else if (take) begin
      idx <= last_beat ? 2'd0 : idx + 2'd1;
    end
  end

  a_idx_in_group: assert property (@(posedge clk) disable iff (rst)
    !q_empty |-> idx < head.count)
    else $error("byte index past end of head group");

endmodule

`default_nettype wire

// ===== hw/rtl/url_percent_codec.sv =====
// URL percent codec, top level. Byte in, zero to three bytes out per beat.
// Each input beat's group is registered in the group queue before it is visible.
// Throughput: one input beat a cycle while each yields one byte and pop is
// high; a three-byte group holds the single output port until all are popped.
// Reset (rst, synchronous): encode mode, default unsafe set, queue empty.
`default_nettype none

module url_percent_codec (
  input  wire logic        clk,
  input  wire logic        rst,
  // config write port: 0 mode, 1..4 unsafe set slices of 64 bits
  input  wire logic        wr_en,
  input  wire logic [2:0]  wr_index,
  input  wire logic [63:0] wr_data,
  // input side, queue style
  input  wire logic        push,
  output      logic        full,
  input  wire logic [7:0]  in_byte,
  input  wire logic        in_last,
  // result side, queue style
  output      logic        empty,
  input  wire logic        pop,
  output      logic [7:0]  out_byte,
  output      logic        out_last
);
  import ucodec_pkg::*;

  cfg_wr_t cfg;
  logic    q_push, q_full, q_pop, q_empty;
  group_t  q_wdata, q_head;

  assign cfg.en    = wr_en;
  assign cfg.index = wr_index;
  assign cfg.data  = wr_data;

  // Input is refused only while the group queue is full; the front end itself
  // never stalls, so full mirrors the queue.
  assign full = q_full;

  // Front: classify the byte, update decoder hold state, build a group of
  // up to three output bytes. Groups with no bytes (held '%' or digit) are
  // not queued.
  ucodec_front u_front (
    .clk     (clk),
    .rst     (rst),
    .cfg     (cfg),
    .push    (push),
    .in_byte (in_byte),
    .in_last (in_last),
    .q_full  (q_full),
    .q_push  (q_push),
    .q_data  (q_wdata)
  );

  // Decouples the front from the result side: a new input beat is taken
  // while the back end is still draining an earlier group.
  ucodec_fifo u_fifo (
    .clk     (clk),
    .rst     (rst),
    .wr      (q_push),
    .wr_data (q_wdata),
    .full    (q_full),
    .rd      (q_pop),
    .rd_data (q_head),
    .empty   (q_empty)
  );

  // Back: hand out the head group one byte per pop; the group leaves the
  // queue with its final byte, which carries out_last for the string end.
  ucodec_back u_back (
    .clk      (clk),
    .rst      (rst),
    .head     (q_head),
    .q_empty  (q_empty),
    .q_pop    (q_pop),
    .pop      (pop),
    .empty    (empty),
    .out_byte (out_byte),
    .out_last (out_last)
  );

endmodule

`default_nettype wire

// ===== test/url_percent_codec_chk.sv =====
// Scoreboard for the URL percent codec: tracks config writes and input beats,
// predicts the output byte stream and compares every popped beat against it.
// Depends on ucodec_pkg for register indexes and the mode/held enums.
module url_percent_codec_chk (
  input  logic                              clk,
  input  logic                              rst,
  input  logic                              wr_en,
  input  logic [ucodec_pkg::REG_IDX_W-1:0]  wr_index,
  input  logic [ucodec_pkg::CFG_DATA_W-1:0] wr_data,
  input  logic                              push,
  input  logic                              full,
  input  logic [7:0]                        in_byte,
  input  logic                              in_last,
  input  logic                              empty,
  input  logic                              pop,
  input  logic [7:0]                        out_byte,
  input  logic                              out_last,
  output int                                waiting,
  output int                                fails
);
  import ucodec_pkg::*;

  typedef struct packed {
    logic [7:0] ch;
    logic       last;
  } out_beat_t;

  localparam logic [255:0] DEFAULT_SET = {64'hFFFF_FFFF_FFFF_FFFF, 64'hFFFF_FFFF_FFFF_FFFF,
                                          64'hF000_0001_7800_0001, 64'hFC00_98FF_FFFF_FFFE};

  mode_t        cur_mode;
  logic [255:0] unsafe_set;
  held_t        held;
  logic [3:0]   held_nib;
  out_beat_t    expected_bytes[$];
  out_beat_t    step_out[$];
  int           err_cnt = 0;

  initial begin
    waiting = 0;
    fails   = 0;
  end

  function automatic logic [7:0] nib_to_ascii(input logic [3:0] nib);
    return (nib < 4'd10) ? 8'h30 + 8'(nib) : 8'h41 + 8'(nib) - 8'd10;
  endfunction

  // bit 4 set: not an uppercase hex digit
  function automatic logic [4:0] ascii_hex_nib(input logic [7:0] c);
    if (c >= 8'h30 && c <= 8'h39) return 5'(c - 8'h30);
    if (c >= 8'h41 && c <= 8'h46) return 5'(c - 8'h41 + 8'd10);
    return 5'h10;
  endfunction

  function automatic void put(input logic [7:0] ch);
    if (step_out.size() < 3) step_out.push_back('{ch: ch, last: 1'b0});
  endfunction

  function automatic void flush_held();
    if (held != HELD_NONE) put(CH_PCT);
    if (held == HELD_DIGIT) put(nib_to_ascii(held_nib));
    held     = HELD_NONE;
    held_nib = 4'd0;
  endfunction

  function automatic void take_fresh(input logic [7:0] b);
    if (b == CH_PCT) held = HELD_PCT;
    else put(b);
  endfunction

  function automatic void apply_cfg(input logic [REG_IDX_W-1:0] idx,
                                    input logic [CFG_DATA_W-1:0] d);
    case (idx)
      REG_MODE: begin
        cur_mode = mode_t'(d[0]);
        held     = HELD_NONE;
        held_nib = 4'd0;
      end
      REG_UNSAFE0: unsafe_set[63:0]    = d;
      REG_UNSAFE1: unsafe_set[127:64]  = d;
      REG_UNSAFE2: unsafe_set[191:128] = d;
      REG_UNSAFE3: unsafe_set[255:192] = d;
      default: ;
    endcase
  endfunction

  function automatic void predict_codec(input logic [7:0] b, input logic lst);
    logic [4:0] dv;
    logic [7:0] val;
    step_out.delete();
    dv = ascii_hex_nib(b);
    if (cur_mode == MODE_ENCODE) begin
      if (unsafe_set[b]) begin
        put(CH_PCT);
        put(nib_to_ascii(b[7:4]));
        put(nib_to_ascii(b[3:0]));
      end else begin
        put(b);
      end
    end else begin
      case (held)
        HELD_NONE: take_fresh(b);
        HELD_PCT: begin
          if (!dv[4]) begin
            held_nib = dv[3:0];
            held     = HELD_DIGIT;
          end else begin
            flush_held();
            take_fresh(b);
          end
        end
        default: begin
          if (!dv[4]) begin
            val = {held_nib, dv[3:0]};
            if (unsafe_set[val]) begin
              put(val);
            end else begin
              put(CH_PCT);
              put(nib_to_ascii(held_nib));
              put(b);
            end
            held     = HELD_NONE;
            held_nib = 4'd0;
          end else begin
            flush_held();
            take_fresh(b);
          end
        end
      endcase
      if (lst) flush_held();
    end
    if (lst && step_out.size() > 0) step_out[step_out.size()-1].last = 1'b1;
    foreach (step_out[k]) expected_bytes.push_back(step_out[k]);
  endfunction

  always @(posedge clk) begin
    out_beat_t want;
    if (rst) begin
      cur_mode   = MODE_ENCODE;
      unsafe_set = DEFAULT_SET;
      held       = HELD_NONE;
      held_nib   = 4'd0;
      expected_bytes.delete();
    end else begin
      if (wr_en) apply_cfg(wr_index, wr_data);
      if (pop && !empty) begin
        if (expected_bytes.size() == 0) begin
          err_cnt++;
          $error("out_byte: expected nothing, actual %02h", out_byte);
        end else begin
          want = expected_bytes.pop_front();
          if (out_byte !== want.ch) begin
            err_cnt++;
            $error("out_byte: expected %02h, actual %02h", want.ch, out_byte);
          end
          if (out_last !== want.last) begin
            err_cnt++;
            $error("out_last: expected %0b, actual %0b", want.last, out_last);
          end
        end
      end
      if (push && !full) predict_codec(in_byte, in_last);
    end
    waiting <= expected_bytes.size();
    fails   <= err_cnt;
  end

endmodule

// ===== test/url_percent_codec_tb.sv =====
// Testbench top for url_percent_codec: clock, reset, config phases and stimulus.
// Depends on ucodec_pkg, the codec RTL and url_percent_codec_chk (the scoreboard).
module url_percent_codec_tb;
  import ucodec_pkg::*;

  // cycles with no beat moving on either side before the run is declared hung;
  // worst honest gap is a stall burst plus a config write sequence
  localparam int STALL_LIMIT = 400;

  logic                  clk      = 1'b0;
  logic                  rst      = 1'b1;
  logic                  wr_en    = 1'b0;
  logic [REG_IDX_W-1:0]  wr_index = '0;
  logic [CFG_DATA_W-1:0] wr_data  = '0;
  logic                  push     = 1'b0;
  logic [7:0]            in_byte  = 8'd0;
  logic                  in_last  = 1'b0;
  logic                  pop      = 1'b0;
  logic                  full;
  logic                  empty;
  logic [7:0]            out_byte;
  logic                  out_last;

  int   waiting;
  int   fails;
  int   pop_gap      = 0;
  int   stall_cycles = 0;
  bit   steady       = 1'b0;  // set in the last phase: no idling on either side
  logic [7:0] tok_q[$];       // pending bytes of the current decode token

  always #10 clk = ~clk;

  url_percent_codec uut (
    .clk      (clk),
    .rst      (rst),
    .wr_en    (wr_en),
    .wr_index (wr_index),
    .wr_data  (wr_data),
    .push     (push),
    .full     (full),
    .in_byte  (in_byte),
    .in_last  (in_last),
    .empty    (empty),
    .pop      (pop),
    .out_byte (out_byte),
    .out_last (out_last)
  );

  url_percent_codec_chk chk (
    .clk      (clk),
    .rst      (rst),
    .wr_en    (wr_en),
    .wr_index (wr_index),
    .wr_data  (wr_data),
    .push     (push),
    .full     (full),
    .in_byte  (in_byte),
    .in_last  (in_last),
    .empty    (empty),
    .pop      (pop),
    .out_byte (out_byte),
    .out_last (out_last),
    .waiting  (waiting),
    .fails    (fails)
  );

  // Result side: pop held high except for random stall bursts.
  always @(posedge clk) begin
    if (pop_gap > 0) begin
      pop_gap <= pop_gap - 1;
      pop     <= 1'b0;
    end else if (!steady && $urandom_range(0, 5) == 0) begin
      pop_gap <= $urandom_range(0, 12);
      pop     <= 1'b0;
    end else begin
      pop <= 1'b1;
    end
  end

  // Watchdog: counts cycles in which no beat is taken on either side.
  always @(posedge clk) begin
    if (rst || (push && !full) || (pop && !empty)) begin
      stall_cycles <= 0;
    end else if (stall_cycles >= STALL_LIMIT) begin
      $display("[url_percent_codec] ERROR");
      $finish;
    end else begin
      stall_cycles <= stall_cycles + 1;
    end
  end

  // One input beat. push stays high afterwards so back-to-back beats need no
  // second assignment in the same step; it drops only for an idle burst or a drain.
  task automatic send_beat(input logic [7:0] b, input logic lst);
    if (!steady && $urandom_range(0, 5) == 0) begin
      push <= 1'b0;
      repeat ($urandom_range(1, 13)) @(posedge clk);
    end
    push    <= 1'b1;
    in_byte <= b;
    in_last <= lst;
    do @(posedge clk); while (full);
  endtask

  task automatic send_str(input string s, input logic mark_last);
    for (int k = 0; k < s.len(); k++) send_beat(s[k], mark_last && (k == s.len() - 1));
  endtask

  // Stop pushing and wait for the scoreboard to run dry; a '%' still held inside
  // the decoder produces no byte of its own, so it is not waited for.
  task automatic drain();
    push <= 1'b0;
    do @(posedge clk); while (waiting != 0);
    repeat (4) @(posedge clk);
  endtask

  task automatic write_reg(input logic [REG_IDX_W-1:0] idx, input logic [CFG_DATA_W-1:0] d);
    wr_en    <= 1'b1;
    wr_index <= idx;
    wr_data  <= d;
    @(posedge clk);
  endtask

  task automatic apply_setup(input mode_t m, input logic [255:0] set);
    write_reg(REG_MODE, CFG_DATA_W'(m));
    for (int k = 0; k < 4; k++) write_reg(REG_IDX_W'(REG_UNSAFE0 + k), set[64*k +: 64]);
    wr_en <= 1'b0;
  endtask

  function automatic logic [7:0] rand_hex_upper();
    if ($urandom_range(0, 1)) return 8'h30 + 8'($urandom_range(0, 9));
    return 8'h41 + 8'($urandom_range(0, 5));
  endfunction

  // Decode stimulus: mostly complete %HH escapes with random digits, the rest
  // truncated escapes, lowercase digits, doubled '%' and plain noise.
  task automatic make_token();
    int r;
    r = $urandom_range(0, 99);
    if (r < 55) begin
      tok_q.push_back(CH_PCT);
      tok_q.push_back(rand_hex_upper());
      tok_q.push_back(rand_hex_upper());
    end else if (r < 65) begin
      tok_q.push_back(CH_PCT);
      tok_q.push_back(rand_hex_upper());
      tok_q.push_back(8'($urandom_range(0, 255)));
    end else if (r < 72) begin
      tok_q.push_back(CH_PCT);
      tok_q.push_back(8'h61 + 8'($urandom_range(0, 5)));
    end else if (r < 78) begin
      tok_q.push_back(CH_PCT);
      tok_q.push_back(CH_PCT);
    end else begin
      tok_q.push_back(8'($urandom_range(0, 255)));
    end
  endtask

  task automatic run_items(input mode_t m, input int count);
    logic [7:0] b;
    tok_q.delete();
    repeat (count) begin
      if (m == MODE_ENCODE) begin
        b = 8'($urandom_range(0, 255));
      end else begin
        if (tok_q.size() == 0) make_token();
        b = tok_q.pop_front();
      end
      send_beat(b, $urandom_range(0, 9) == 0);
    end
  endtask

  initial begin
    logic [255:0] set;
    mode_t        m;
    repeat (6) @(posedge clk);
    rst <= 1'b0;

    // Encode with the reset set: a safe byte, the top byte, a letter, and
    // '%' itself (unsafe) closing the string.
    send_beat(8'h00, 1'b0);
    send_beat(8'hFF, 1'b0);
    send_beat(8'h41, 1'b0);
    send_beat(CH_PCT, 1'b1);

    drain();
    write_reg(REG_MODE, CFG_DATA_W'(MODE_DECODE));
    wr_en <= 1'b0;

    send_str("%3D", 1'b1);    // decodes to '=', last lands on the decoded byte
    send_str("%41", 1'b0);    // value not in the set: all three bytes go out raw
    send_str("%2a", 1'b0);    // lowercase digit breaks the escape
    send_str("%%3D", 1'b0);   // second '%' breaks the first and starts over
    send_str("%253D", 1'b0);  // single pass: '%' then "3D" stays raw
    send_str("%4", 1'b1);     // half escape flushed on last
    send_str("%", 1'b1);      // lone '%' flushed on last

    // Random phases: empty set, full set in both directions, then random sets.
    for (int p = 0; p < 8; p++) begin
      drain();
      case (p)
        0: apply_setup(MODE_ENCODE, '0);
        1: apply_setup(MODE_ENCODE, '1);
        2: apply_setup(MODE_DECODE, '1);
        3: apply_setup(MODE_DECODE, '0);
        default: begin
          for (int k = 0; k < 8; k++) set[32*k +: 32] = $urandom;
          m = (p == 5) ? MODE_ENCODE :
              (p == 7) ? mode_t'($urandom_range(0, 1)) : MODE_DECODE;
          // indexes past the last slice must be ignored
          if (p == 6) for (int k = 1; k <= 3; k++)
            write_reg(REG_IDX_W'(REG_UNSAFE3 + k), {$urandom, $urandom});
          apply_setup(m, set);
        end
      endcase
      if (p < 4) m = (p < 2) ? MODE_ENCODE : MODE_DECODE;
      steady = (p == 7);
      run_items(m, 43);
    end

    drain();
    repeat (8) @(posedge clk);
    if (fails == 0) begin
      $display("[url_percent_codec] OK");
    end else begin
      $display("[url_percent_codec] ERROR");
    end
    $finish;
  end

endmodule
